>>> src/bmhpq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the binary min-heap priority queue.
// No dependencies.
package bmhpq_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CHILD_W  = IDX_W + 1;
   localparam int OCC_W    = 7;
   localparam int PRIO_W   = 16;
   localparam int PAY_W    = 32;

   typedef struct packed {
      logic signed [PRIO_W-1:0] prio;
      logic signed [PAY_W-1:0]  pay;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_POP    = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_POP_RD,
      ST_POP_LD,
      ST_DN_RDL,
      ST_DN_RDR,
      ST_DN_CMPR,
      ST_DN_DEC,
      ST_PLACE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } ram_wr_type;

   typedef struct packed {
      entry_type             top;
      logic                  is_empty;
      logic [OCC_W-1:0]      occupancy;
      status_type            status;
   } result_type;

endpackage

>>> src/bmhpq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmhpq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/bmhpq_cmp.sv
`timescale 1ns / 1ps
// Shared entry compare unit: a ranks before b (priority, then payload, signed).
// Depends on bmhpq_pkg.
module bmhpq_cmp (
   input  bmhpq_pkg::entry_type a,
   input  bmhpq_pkg::entry_type b,
   output logic                 ranks_first
);

   always_comb begin
      if (a.prio != b.prio) begin
         ranks_first = (a.prio < b.prio);
      end else begin
         ranks_first = (a.pay < b.pay);
      end
   end

endmodule

>>> src/bmhpq_ctrl.sv
`timescale 1ns / 1ps
// Sift-up / sift-down sequencer driving the heap RAM and the compare unit.
// Depends on bmhpq_pkg.
module bmhpq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_cmd,
   input  bmhpq_pkg::entry_type    req_entry,
   input  logic                    out_free,
   output logic                    done,
   output bmhpq_pkg::result_type   result,
   output bmhpq_pkg::ram_wr_type   ram_wr,
   output logic [bmhpq_pkg::IDX_W-1:0] ram_rd_addr,
   input  bmhpq_pkg::entry_type    ram_rd_data,
   output bmhpq_pkg::entry_type    cmp_a,
   output bmhpq_pkg::entry_type    cmp_b,
   input  logic                    cmp_before
);

   bmhpq_pkg::state_type            state_ff, state_in;
   bmhpq_pkg::entry_type            cur_ff, cur_in;
   bmhpq_pkg::entry_type            best_ff, best_in;
   bmhpq_pkg::entry_type            top_ff, top_in;
   logic [bmhpq_pkg::IDX_W-1:0]     pos_ff, pos_in;
   logic [bmhpq_pkg::IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic                            moved_ff, moved_in;
   logic [bmhpq_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   bmhpq_pkg::status_type           status_ff, status_in;

   logic [bmhpq_pkg::IDX_W-1:0]     parent_idx;
   logic [bmhpq_pkg::CHILD_W-1:0]   left_idx;
   logic [bmhpq_pkg::CHILD_W-1:0]   right_idx;
   logic [bmhpq_pkg::CHILD_W-1:0]   cnt_ext;

   assign parent_idx = (pos_ff - bmhpq_pkg::IDX_W'(1)) >> 1;
   assign left_idx   = {pos_ff, 1'b1};
   assign right_idx  = left_idx + bmhpq_pkg::CHILD_W'(1);
   assign cnt_ext    = bmhpq_pkg::CHILD_W'(cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmhpq_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      cur_ff      <= cur_in;
      best_ff     <= best_in;
      top_ff      <= top_in;
      pos_ff      <= pos_in;
      best_idx_ff <= best_idx_in;
      moved_ff    <= moved_in;
      status_ff   <= status_in;
   end

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      best_in     = best_ff;
      top_in      = top_ff;
      pos_in      = pos_ff;
      best_idx_in = best_idx_ff;
      moved_in    = moved_ff;
      cnt_in      = cnt_ff;
      status_in   = status_ff;
      ram_wr      = '{en: 1'b0, addr: pos_ff, data: cur_ff};
      ram_rd_addr = pos_ff;
      cmp_a       = cur_ff;
      cmp_b       = ram_rd_data;
      req_stall   = (state_ff != bmhpq_pkg::ST_IDLE);
      done        = 1'b0;

      case (state_ff)
         bmhpq_pkg::ST_IDLE: begin
            if (req_valid) begin
               status_in = bmhpq_pkg::STATUS_OK;
               if (req_cmd == bmhpq_pkg::CMD_INSERT) begin
                  if (cnt_ff >= bmhpq_pkg::CNT_W'(bmhpq_pkg::CAPACITY)) begin
                     status_in = bmhpq_pkg::STATUS_FULL;
                     state_in  = bmhpq_pkg::ST_DONE;
                  end else begin
                     cur_in   = req_entry;
                     pos_in   = cnt_ff[bmhpq_pkg::IDX_W-1:0];
                     cnt_in   = cnt_ff + bmhpq_pkg::CNT_W'(1);
                     state_in = bmhpq_pkg::ST_UP_RD;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     status_in = bmhpq_pkg::STATUS_EMPTY;
                     state_in  = bmhpq_pkg::ST_DONE;
                  end else begin
                     cnt_in = cnt_ff - bmhpq_pkg::CNT_W'(1);
                     if (cnt_ff == bmhpq_pkg::CNT_W'(1)) begin
                        state_in = bmhpq_pkg::ST_DONE;
                     end else begin
                        state_in = bmhpq_pkg::ST_POP_RD;
                     end
                  end
               end
            end
         end
         bmhpq_pkg::ST_UP_RD: begin
            if (pos_ff == '0) begin
               state_in = bmhpq_pkg::ST_PLACE;
            end else begin
               ram_rd_addr = parent_idx;
               state_in    = bmhpq_pkg::ST_UP_CMP;
            end
         end
         bmhpq_pkg::ST_UP_CMP: begin
            // moving entry vs parent; hole moves up on a win
            if (cmp_before) begin
               ram_wr   = '{en: 1'b1, addr: pos_ff, data: ram_rd_data};
               pos_in   = parent_idx;
               state_in = bmhpq_pkg::ST_UP_RD;
            end else begin
               state_in = bmhpq_pkg::ST_PLACE;
            end
         end
         bmhpq_pkg::ST_POP_RD: begin
            ram_rd_addr = cnt_ff[bmhpq_pkg::IDX_W-1:0];
            state_in    = bmhpq_pkg::ST_POP_LD;
         end
         bmhpq_pkg::ST_POP_LD: begin
            cur_in   = ram_rd_data;
            pos_in   = '0;
            state_in = bmhpq_pkg::ST_DN_RDL;
         end
         bmhpq_pkg::ST_DN_RDL: begin
            if (left_idx >= cnt_ext) begin
               state_in = bmhpq_pkg::ST_PLACE;
            end else begin
               ram_rd_addr = left_idx[bmhpq_pkg::IDX_W-1:0];
               state_in    = bmhpq_pkg::ST_DN_RDR;
            end
         end
         bmhpq_pkg::ST_DN_RDR: begin
            cmp_a       = ram_rd_data;
            cmp_b       = cur_ff;
            best_in     = cmp_before ? ram_rd_data : cur_ff;
            best_idx_in = left_idx[bmhpq_pkg::IDX_W-1:0];
            moved_in    = cmp_before;
            if (right_idx < cnt_ext) begin
               ram_rd_addr = right_idx[bmhpq_pkg::IDX_W-1:0];
               state_in    = bmhpq_pkg::ST_DN_CMPR;
            end else begin
               state_in = bmhpq_pkg::ST_DN_DEC;
            end
         end
         bmhpq_pkg::ST_DN_CMPR: begin
            cmp_a = ram_rd_data;
            cmp_b = best_ff;
            if (cmp_before) begin
               best_in     = ram_rd_data;
               best_idx_in = right_idx[bmhpq_pkg::IDX_W-1:0];
               moved_in    = 1'b1;
            end
            state_in = bmhpq_pkg::ST_DN_DEC;
         end
         bmhpq_pkg::ST_DN_DEC: begin
            if (moved_ff) begin
               ram_wr = '{en: 1'b1, addr: pos_ff, data: best_ff};
               if (pos_ff == '0) begin
                  top_in = best_ff;
               end
               pos_in   = best_idx_ff;
               state_in = bmhpq_pkg::ST_DN_RDL;
            end else begin
               state_in = bmhpq_pkg::ST_PLACE;
            end
         end
         bmhpq_pkg::ST_PLACE: begin
            ram_wr = '{en: 1'b1, addr: pos_ff, data: cur_ff};
            if (pos_ff == '0) begin
               top_in = cur_ff;
            end
            state_in = bmhpq_pkg::ST_DONE;
         end
         bmhpq_pkg::ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = bmhpq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bmhpq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      result.is_empty  = (cnt_ff == '0);
      result.top       = result.is_empty ? '1 : top_ff;
      result.occupancy = bmhpq_pkg::OCC_W'(cnt_ff);
      result.status    = status_ff;
   end

endmodule

>>> src/binary_min_heap_priority_queue.sv
`timescale 1ns / 1ps
// Binary min-heap priority queue, top level: heap RAM, compare unit, sequencer
// and response register. Depends on bmhpq_pkg, bmhpq_ram, bmhpq_cmp, bmhpq_ctrl.
//
// Usage:
//  - Request channel (req_valid / req_stall): req_cmd selects insert or pop;
//    req_priority_req and req_payload give the entry to insert (ignored on pop).
//    Smaller priority is served first, ties go to the smaller payload.
//  - Response channel (rsp_valid / rsp_stall): one response per request with the
//    minimum entry (all ones when empty), empty flag, occupancy and status
//    (ok, insert dropped because full, pop on empty ignored).
//  - One request at a time: req_stall is high from acceptance until the
//    response is loaded. All heap traffic goes through one RAM port pair and one
//    compare unit, so the walk length sets the latency; a pop reads up to two
//    children per level. A full insert, a pop on empty and a pop of the last
//    entry go straight to the response. The next request is taken in the
//    cycle after the response is loaded.
//  - A finished response sits in the output register; the next request can be
//    taken while it waits. If rsp_stall holds the register, a later response
//    waits in the sequencer until it drains.
//  - Reset (synchronous) empties the queue; RAM contents are not cleared, but
//    no entry is used that was not written since reset.
module binary_min_heap_priority_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic signed [15:0] req_priority_req,
   input  logic signed [31:0] req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_top_priority,
   output logic signed [31:0] rsp_top_payload,
   output logic               rsp_is_empty,
   output logic [6:0]         rsp_occupancy,
   output logic [1:0]         rsp_status
);

   bmhpq_pkg::entry_type              req_entry;
   bmhpq_pkg::entry_type              ram_rd_data;
   bmhpq_pkg::entry_type              cmp_a;
   bmhpq_pkg::entry_type              cmp_b;
   bmhpq_pkg::ram_wr_type             ram_wr;
   bmhpq_pkg::result_type             result;
   logic [bmhpq_pkg::IDX_W-1:0]       ram_rd_addr;
   logic                              cmp_before;
   logic                              out_free;
   logic                              done;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   bmhpq_pkg::result_type             rsp_ff, rsp_in;

   assign req_entry = '{prio: req_priority_req, pay: req_payload};
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   bmhpq_ram #(
      .WIDTH (bmhpq_pkg::ENTRY_W),
      .DEPTH (bmhpq_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bmhpq_cmp u_cmp (
      .a           (cmp_a),
      .b           (cmp_b),
      .ranks_first (cmp_before)
   );

   bmhpq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_entry   (req_entry),
      .out_free    (out_free),
      .done        (done),
      .result      (result),
      .ram_wr      (ram_wr),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .cmp_a       (cmp_a),
      .cmp_b       (cmp_b),
      .cmp_before  (cmp_before)
   );

   // load on done (only raised when the register is free), drain on !stall
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_top_priority = rsp_ff.top.prio;
   assign rsp_top_payload  = rsp_ff.top.pay;
   assign rsp_is_empty     = rsp_ff.is_empty;
   assign rsp_occupancy    = rsp_ff.occupancy;
   assign rsp_status       = rsp_ff.status;

   // a taken request always leaves the block busy in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while block not busy afterwards");

   // sequencer never overwrites a response still held by the receiver
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten while stalled");

   // empty flag agrees with occupancy
   a_empty_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_occupancy == '0)))
      else $error("empty flag and occupancy disagree");

   // a dropped insert only happens at full capacity
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bmhpq_pkg::STATUS_FULL)
         |-> (rsp_occupancy == bmhpq_pkg::OCC_W'(bmhpq_pkg::CAPACITY)))
      else $error("full status below capacity");

endmodule

>>> dv/binary_min_heap_priority_queue_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for binary_min_heap_priority_queue: inserts and pops
// checked against a local heap model. Depends on bmhpq_pkg and the block's RTL.
module binary_min_heap_priority_queue_test;

   // Mirror of the heap plus the queue of responses still owed by the block.
   class heap_scoreboard;
      bmhpq_pkg::entry_type  slot [bmhpq_pkg::CAPACITY];
      int                    fill = 0;
      bmhpq_pkg::result_type owed_q [$];
      int                    failures = 0;
      int                    inserts = 0;
      int                    pops = 0;
      int                    full_drops = 0;
      int                    empty_pops = 0;
      int                    peak = 0;

      // Smaller priority first; equal priority falls back to smaller payload.
      function bit precedes(bmhpq_pkg::entry_type a, bmhpq_pkg::entry_type b);
         if (a.prio != b.prio)
            return $signed(a.prio) < $signed(b.prio);
         return $signed(a.pay) < $signed(b.pay);
      endfunction

      function void note_request(bmhpq_pkg::cmd_type c, logic signed [15:0] p,
                                 logic signed [31:0] d);
         bmhpq_pkg::result_type r;
         bmhpq_pkg::entry_type  t;
         int                    pos;
         int                    up;
         int                    best;
         int                    lc;
         bit                    settled;
         r.status = bmhpq_pkg::STATUS_OK;
         if (c == bmhpq_pkg::CMD_INSERT) begin
            inserts++;
            if (fill >= bmhpq_pkg::CAPACITY) begin
               r.status = bmhpq_pkg::STATUS_FULL;
               full_drops++;
            end else begin
               slot[fill].prio = p;
               slot[fill].pay  = d;
               pos = fill;
               fill++;
               settled = 0;
               while (pos > 0 && !settled) begin
                  up = (pos - 1) / 2;
                  if (precedes(slot[pos], slot[up])) begin
                     t = slot[pos];
                     slot[pos] = slot[up];
                     slot[up] = t;
                     pos = up;
                  end else begin
                     settled = 1;
                  end
               end
            end
         end else begin
            pops++;
            if (fill == 0) begin
               r.status = bmhpq_pkg::STATUS_EMPTY;
               empty_pops++;
            end else begin
               fill--;
               slot[0] = slot[fill];
               pos = 0;
               settled = 0;
               while (!settled) begin
                  lc = 2 * pos + 1;
                  best = pos;
                  if (lc < fill && precedes(slot[lc], slot[best]))
                     best = lc;
                  if (lc + 1 < fill && precedes(slot[lc + 1], slot[best]))
                     best = lc + 1;
                  if (best == pos) begin
                     settled = 1;
                  end else begin
                     t = slot[pos];
                     slot[pos] = slot[best];
                     slot[best] = t;
                     pos = best;
                  end
               end
            end
         end
         if (fill > peak)
            peak = fill;
         if (fill == 0) begin
            r.top = '1;
         end else begin
            r.top = slot[0];
         end
         r.is_empty  = (fill == 0);
         r.occupancy = fill[bmhpq_pkg::OCC_W-1:0];
         owed_q.push_back(r);
      endfunction

      function void check_response(logic signed [15:0] tp, logic signed [31:0] tpay,
                                   logic e, logic [6:0] occ, logic [1:0] st);
         bmhpq_pkg::result_type want;
         if (owed_q.size() == 0) begin
            $error("response with nothing owed: top_priority %0d top_payload %0d",
                   tp, tpay);
            failures++;
            return;
         end
         want = owed_q.pop_front();
         if (want.top.prio !== tp) begin
            $error("top_priority expected %0d actual %0d", $signed(want.top.prio), tp);
            failures++;
         end
         if (want.top.pay !== tpay) begin
            $error("top_payload expected %0d actual %0d", $signed(want.top.pay), tpay);
            failures++;
         end
         if (want.is_empty !== e) begin
            $error("is_empty expected %0d actual %0d", want.is_empty, e);
            failures++;
         end
         if (want.occupancy !== occ) begin
            $error("occupancy expected %0d actual %0d", want.occupancy, occ);
            failures++;
         end
         if (want.status !== st) begin
            $error("status expected %0d actual %0d", want.status, st);
            failures++;
         end
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_cmd = 1'b0;
   logic signed [15:0] req_priority_req = '0;
   logic signed [31:0] req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_top_priority;
   logic signed [31:0] rsp_top_payload;
   logic               rsp_is_empty;
   logic [6:0]         rsp_occupancy;
   logic [1:0]         rsp_status;

   heap_scoreboard sb;
   int             send_idle_pct = 16;   // chance per cycle that the sender holds off
   int             recv_idle_pct = 68;   // chance per cycle that the receiver stalls

   binary_min_heap_priority_queue DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_priority_req (req_priority_req),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_top_priority (rsp_top_priority),
      .rsp_top_payload  (rsp_top_payload),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_status       (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop: worst case is roughly 1600 requests, each with its heap walk,
   // stretched by long gaps and stalls; this allows several times that.
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   // Receiver: stall pattern changes only on the falling edge.
   always @(negedge clock) begin
      if (!reset)
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
   end

   // Response monitor: a response moves at a rising edge with valid high and
   // stall low; values seen here are the ones from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_top_priority, rsp_top_payload, rsp_is_empty,
                           rsp_occupancy, rsp_status);
   end

   // Drive one request. Entered and left on a falling edge; valid stays high
   // on exit so back-to-back requests need no toggle. The payload is held
   // untouched while the block stalls.
   task automatic send_request(input bmhpq_pkg::cmd_type c,
                               input logic signed [15:0] p,
                               input logic signed [31:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_cmd          = c;
      req_priority_req = p;
      req_payload      = d;
      do
         @(posedge clock);
      while (req_stall);
      sb.note_request(c, p, d);
      @(negedge clock);
   endtask

   // Stop sending and let every owed response come back.
   task automatic drain_responses();
      req_valid = 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
   endtask

   // Random traffic in bursts. Each run opens with a fill burst (reaches the
   // full-drop case) and a drain burst (reaches pop on empty); after that the
   // mix is chosen per burst. Half of the priorities sit in a narrow band so that
   // ties and payload tie-breaks are common.
   task automatic run_random(input int count);
      int                 burst;
      int                 left;
      int                 insert_pct;
      int                 pick;
      bmhpq_pkg::cmd_type c;
      logic signed [15:0] p;
      logic signed [31:0] d;
      burst = 0;
      left  = 0;
      insert_pct = 50;
      repeat (count) begin
         if (left == 0) begin
            case (burst)
               0:       insert_pct = 85;
               1:       insert_pct = 15;
               default: begin
                  pick = $urandom_range(2);
                  insert_pct = (pick == 0) ? 85 : (pick == 1) ? 15 : 50;
               end
            endcase
            left = (burst < 2) ? 110 : $urandom_range(20, 120);
            burst++;
         end
         left--;
         c = ($urandom_range(99) < insert_pct) ? bmhpq_pkg::CMD_INSERT
                                               : bmhpq_pkg::CMD_POP;
         pick = $urandom_range(9);
         if (pick < 4)
            p = 16'($urandom_range(15)) - 16'd8;
         else if (pick < 8)
            p = 16'($urandom);
         else if (pick == 8)
            p = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         else
            p = 16'sd0;
         pick = $urandom_range(9);
         if (pick < 4)
            d = 32'($urandom_range(7)) - 32'd4;
         else if (pick < 9)
            d = $urandom;
         else
            d = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         send_request(c, p, d);
      end
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: pop on empty, extreme entries, equal-priority ties settled
      // by payload, an entry that looks like the empty marker, then drain the
      // queue and pop once more on empty.
      send_request(bmhpq_pkg::CMD_POP,    16'sd0,      32'sd0);
      send_request(bmhpq_pkg::CMD_INSERT, 16'sd0,      32'sd0);
      send_request(bmhpq_pkg::CMD_INSERT, 16'sh7fff,   32'sh7fffffff);
      send_request(bmhpq_pkg::CMD_INSERT, 16'sh8000,   32'sh80000000);
      send_request(bmhpq_pkg::CMD_INSERT, 16'sh8000,   32'sh7fffffff);
      send_request(bmhpq_pkg::CMD_INSERT, 16'sh8000,   -32'sd1);
      send_request(bmhpq_pkg::CMD_INSERT, 16'sd5,      32'sd5);
      send_request(bmhpq_pkg::CMD_INSERT, 16'sd5,      -32'sd5);
      send_request(bmhpq_pkg::CMD_INSERT, -16'sd1,     -32'sd1);
      repeat (9)
         send_request(bmhpq_pkg::CMD_POP, 16'sh7fff, 32'sh7fffffff);

      // Phase 1: sender idles lightly, receiver stalls heavily.
      run_random(510);
      drain_responses();

      // Phase 2: the other way round.
      send_idle_pct = 68;
      recv_idle_pct = 16;
      run_random(510);
      drain_responses();

      // Phase 3: full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(512);
      drain_responses();
      repeat (40) @(negedge clock);

      if (sb.pending() != 0)
         sb.failures++;
      $display("Ran %0d inserts (%0d dropped while full) and %0d pops (%0d on empty),",
               sb.inserts, sb.full_drops, sb.pops, sb.empty_pops);
      $display("peak occupancy %0d, under three idle and stall patterns.", sb.peak);
      if (sb.failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
